// ===== rtl/emc_pkg.sv =====
package emc_pkg;

  // Widths fixed by the item and register formats
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned LEVEL_W = 5;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 16;

  // Command queue depth default
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Hand-off queue between front and back
  localparam int unsigned ITEMQ_DEPTH = 2;

  // Product dist * duty_max, and the serial divider step counter
  localparam int unsigned PROD_W = COUNT_W + DUTY_W;
  localparam int unsigned STEP_W = $clog2(PROD_W);

  // Request codes
  localparam logic REQ_CMD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Direction codes
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_COUNTS_PER_REV = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DUTY_MAX       = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DUTY_MIN       = 2'd2;

  // Configuration reset values
  localparam logic [COUNT_W-1:0] CPR_RST      = 16'd4480;
  localparam logic [DUTY_W-1:0]  DUTY_MAX_RST = 8'd100;
  localparam logic [DUTY_W-1:0]  DUTY_MIN_RST = 8'd0;

  typedef struct packed {
    logic [COUNT_W-1:0] counts_per_rev;
    logic [DUTY_W-1:0]  duty_max;
    logic [DUTY_W-1:0]  duty_min;
  } cfg_t;

  // Classified item as passed from front to back
  typedef struct packed {
    logic               is_tick;
    logic               dir;
    logic [COUNT_W-1:0] count;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic               drive_dir;
    logic               moving;
    logic               cmd_dropped;
    logic [LEVEL_W-1:0] queue_level;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FETCH,
    B_EVAL,
    B_DIV,
    B_CLAMP,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/emc_ram.sv =====
module emc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = emc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/emc_front.sv =====
module emc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic                          cmd_dir,
  input  logic [emc_pkg::COUNT_W-1:0]   position,
  output logic                          item_valid,
  input  logic                          item_ready,
  output emc_pkg::item_t                item
);

  localparam int unsigned PTR_W = $clog2(emc_pkg::ITEMQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(emc_pkg::ITEMQ_DEPTH + 1);

  emc_pkg::item_t     slots [emc_pkg::ITEMQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  emc_pkg::item_t     in_item;
  logic               push;
  logic               pop;

  always_comb begin
    in_item.is_tick = (req_type == emc_pkg::REQ_TICK);
    in_item.dir     = cmd_dir;
    in_item.count   = position;
  end

  assign in_ready   = (count != CNT_W'(emc_pkg::ITEMQ_DEPTH));
  assign item_valid = (count != '0);
  assign item       = slots[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(emc_pkg::ITEMQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(emc_pkg::ITEMQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/emc_back.sv =====
module emc_back #(
  parameter int unsigned QUEUE_DEPTH = emc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  emc_pkg::cfg_t  cfg,
  input  logic           item_valid,
  output logic           item_ready,
  input  emc_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output emc_pkg::res_t  res
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CW     = emc_pkg::COUNT_W;
  localparam int unsigned DW     = emc_pkg::DUTY_W;
  localparam int unsigned PW     = emc_pkg::PROD_W;

  emc_pkg::back_state_t state;
  emc_pkg::back_state_t state_next;

  logic [PTR_W-1:0]          read_ptr;
  logic [PTR_W-1:0]          write_ptr;
  logic [FILL_W-1:0]         fill_count;
  logic [CW-1:0]             target_pos;
  logic                      move_active;
  logic                      current_dir;
  emc_pkg::item_t            cur;
  logic [PW-1:0]             dv;
  logic [CW-1:0]             rem;
  logic [emc_pkg::STEP_W-1:0] step;
  logic [DW-1:0]             res_duty;
  logic                      res_dropped;

  logic                      full;
  logic                      start_move;
  logic [CW-1:0]             distance;
  logic                      saturate;
  logic [CW:0]               trial;
  logic                      take;
  logic [CW:0]               trial_sub;
  logic [DW-1:0]             capped;
  logic [DW-1:0]             clamped;
  logic                      ram_we;
  logic                      ram_rdata;
  logic                      out_free;

  emc_ram #(
    .WIDTH (1),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata (item.dir),
    .raddr (read_ptr),
    .rdata (ram_rdata)
  );

  assign full       = (fill_count == FILL_W'(QUEUE_DEPTH));
  assign start_move = !move_active && (fill_count != '0);
  assign distance   = (target_pos >= cur.count) ? (target_pos - cur.count)
                                                : (cur.count - target_pos);
  // distance >= counts_per_rev means the quotient is at least duty_max
  assign saturate   = (cfg.counts_per_rev == '0) || (distance >= cfg.counts_per_rev);
  assign trial      = {rem, dv[PW-1]};
  assign take       = (trial >= {1'b0, cfg.counts_per_rev});
  assign trial_sub  = trial - {1'b0, cfg.counts_per_rev};
  assign capped     = (dv > PW'(cfg.duty_max)) ? cfg.duty_max : dv[DW-1:0];
  assign clamped    = (capped < cfg.duty_min) ? cfg.duty_min : capped;
  assign out_free   = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      emc_pkg::B_IDLE: begin
        if (item_valid) begin
          if (!item.is_tick) begin
            state_next = emc_pkg::B_DONE;
          end else if (start_move) begin
            state_next = emc_pkg::B_FETCH;
          end else if (move_active) begin
            state_next = emc_pkg::B_EVAL;
          end else begin
            state_next = emc_pkg::B_DONE;
          end
        end
      end
      emc_pkg::B_FETCH: state_next = emc_pkg::B_EVAL;
      emc_pkg::B_EVAL: begin
        if (distance == '0) begin
          state_next = emc_pkg::B_DONE;
        end else if (saturate) begin
          state_next = emc_pkg::B_CLAMP;
        end else begin
          state_next = emc_pkg::B_DIV;
        end
      end
      emc_pkg::B_DIV: begin
        if (step == emc_pkg::STEP_W'(PW - 1)) begin
          state_next = emc_pkg::B_CLAMP;
        end
      end
      emc_pkg::B_CLAMP: state_next = emc_pkg::B_DONE;
      emc_pkg::B_DONE: begin
        if (out_free) begin
          state_next = emc_pkg::B_IDLE;
        end
      end
      default: state_next = emc_pkg::B_IDLE;
    endcase
  end

  // State-decoded controls
  always_comb begin
    item_ready = (state == emc_pkg::B_IDLE);
    ram_we     = (state == emc_pkg::B_IDLE) && item_valid && !item.is_tick && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= emc_pkg::B_IDLE;
      read_ptr    <= '0;
      write_ptr   <= '0;
      fill_count  <= '0;
      target_pos  <= '0;
      move_active <= 1'b0;
      current_dir <= emc_pkg::DIR_CW;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == emc_pkg::B_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        emc_pkg::B_IDLE: begin
          if (item_valid) begin
            cur         <= item;
            res_duty    <= '0;
            res_dropped <= 1'b0;
            if (!item.is_tick) begin
              if (!full) begin
                write_ptr  <= (write_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : write_ptr + 1'b1;
                fill_count <= fill_count + 1'b1;
              end else begin
                res_dropped <= 1'b1;
              end
            end
          end
        end
        emc_pkg::B_FETCH: begin
          current_dir <= ram_rdata;
          read_ptr    <= (read_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : read_ptr + 1'b1;
          fill_count  <= fill_count - 1'b1;
          target_pos  <= (ram_rdata == emc_pkg::DIR_CW) ? cur.count + cfg.counts_per_rev
                                                         : cur.count - cfg.counts_per_rev;
          move_active <= 1'b1;
        end
        emc_pkg::B_EVAL: begin
          rem  <= '0;
          step <= '0;
          if (distance == '0) begin
            move_active <= 1'b0;
          end else if (saturate) begin
            dv <= PW'(cfg.duty_max);
          end else begin
            dv <= PW'(distance) * PW'(cfg.duty_max);
          end
        end
        emc_pkg::B_DIV: begin
          rem  <= take ? trial_sub[CW-1:0] : trial[CW-1:0];
          dv   <= {dv[PW-2:0], take};
          step <= step + 1'b1;
        end
        emc_pkg::B_CLAMP: begin
          res_duty <= clamped;
        end
        emc_pkg::B_DONE: begin
          if (out_free) begin
            res.duty        <= res_duty;
            res.drive_dir   <= current_dir;
            res.moving      <= move_active;
            res.cmd_dropped <= res_dropped;
            res.queue_level <= emc_pkg::LEVEL_W'(fill_count);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/encoder_move_controller.sv =====
// Channel  | handshake           | payload
// in       | in_valid/in_ready   | req_type, cmd_dir, position
// out      | out_valid/out_ready | duty, drive_dir, moving, cmd_dropped, queue_level
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each item gives one result. Taken by the back end, an enqueue or idle tick goes to DONE,
// which loads the result register; a move tick goes via FETCH (on a start) and EVAL to DONE
// when the move ends, else via CLAMP, after the 24-step serial divide by counts_per_rev when
// not saturated. Synchronous active-high reset clears all control state and loads the
// register defaults; no clearing pass. A result left waiting holds the back end in its last
// state; the two-item hand-off queue then fills and the input stalls.
module encoder_move_controller #(
  parameter int unsigned QUEUE_DEPTH = emc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic                          cmd_dir,
  input  logic [emc_pkg::COUNT_W-1:0]   position,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [emc_pkg::DUTY_W-1:0]    duty,
  output logic                          drive_dir,
  output logic                          moving,
  output logic                          cmd_dropped,
  output logic [emc_pkg::LEVEL_W-1:0]   queue_level,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [emc_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [emc_pkg::CDATA_W-1:0]   cfg_data
);

  emc_pkg::cfg_t  cfg;
  emc_pkg::item_t item;
  emc_pkg::res_t  res;
  logic           item_valid;
  logic           item_ready;

  // Register file: always ready, a write takes effect on the next cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counts_per_rev <= emc_pkg::CPR_RST;
      cfg.duty_max       <= emc_pkg::DUTY_MAX_RST;
      cfg.duty_min       <= emc_pkg::DUTY_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        emc_pkg::CFG_COUNTS_PER_REV: cfg.counts_per_rev <= cfg_data;
        emc_pkg::CFG_DUTY_MAX:       cfg.duty_max       <= cfg_data[emc_pkg::DUTY_W-1:0];
        emc_pkg::CFG_DUTY_MIN:       cfg.duty_min       <= cfg_data[emc_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: accepts and classifies items into the hand-off queue
  emc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .cmd_dir    (cmd_dir),
    .position   (position),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // Back end: command FIFO, move tracking, proportional duty and result register
  emc_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign duty        = res.duty;
  assign drive_dir   = res.drive_dir;
  assign moving      = res.moving;
  assign cmd_dropped = res.cmd_dropped;
  assign queue_level = res.queue_level;

endmodule

// ===== bench/tb_encoder_move_controller.sv =====
`timescale 1ns / 1ps

module tb_encoder_move_controller;
  import emc_pkg::*;

  // Queue depth of the block as built, the ignored register slot, and run bounds
  localparam int unsigned CMDQ_DEPTH   = QUEUE_DEPTH_DEF;
  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned REPORT_MAX   = 10;

  // One row of the directed script; want is only used when typed is set
  typedef struct packed {
    logic          req;
    logic          dir;
    logic [COUNT_W-1:0] cnt;
    bit            typed;
    res_t          want;
  } stim_row_t;

  // Clock, reset and every block input start at known values
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic req_type = REQ_CMD;
  logic cmd_dir = DIR_CW;
  logic [COUNT_W-1:0] position = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CIDX_W-1:0] cfg_index = CFG_COUNTS_PER_REV;
  logic [CDATA_W-1:0] cfg_data = '0;

  logic in_ready, out_valid, cfg_ready;
  logic [DUTY_W-1:0] duty;
  logic drive_dir, moving, cmd_dropped;
  logic [LEVEL_W-1:0] queue_level;

  encoder_move_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .cmd_dir(cmd_dir), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .duty(duty), .drive_dir(drive_dir), .moving(moving),
    .cmd_dropped(cmd_dropped), .queue_level(queue_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the controller: register copies, command ring, move state
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] rev_counts = CPR_RST;
  logic [DUTY_W-1:0]  top_duty   = DUTY_MAX_RST;
  logic [DUTY_W-1:0]  floor_duty = DUTY_MIN_RST;

  logic               pend_dir [CMDQ_DEPTH];
  int unsigned        head = 0;
  int unsigned        tail = 0;
  int unsigned        backlog = 0;
  logic [COUNT_W-1:0] goal = '0;
  logic               busy = 1'b0;
  logic               heading = DIR_CW;

  // Drive results still owed by the block, oldest first
  res_t pending_drive[$];

  int unsigned fault_count = 0;
  int unsigned cycles = 0;

  // Stimulus shaping, set per phase
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req = 1'b0;
  logic [COUNT_W-1:0] walk = '0;  // last tick count offered

  // Register write as the block sees it; index beyond the last register is ignored
  function automatic void shadow_reg(input logic [CIDX_W-1:0] idx,
                                     input logic [CDATA_W-1:0] data);
    case (idx)
      CFG_COUNTS_PER_REV: rev_counts = data;
      CFG_DUTY_MAX:       top_duty = data[DUTY_W-1:0];
      CFG_DUTY_MIN:       floor_duty = data[DUTY_W-1:0];
      default: ;
    endcase
  endfunction

  // Works out the drive result of one accepted item and advances the shadow
  function automatic res_t motor_response(input item_t it);
    res_t r;
    logic [COUNT_W-1:0] span;
    logic [31:0] scaled, span32, top32, rev32;
    r = '0;
    if (it.is_tick == REQ_CMD) begin
      if (backlog < CMDQ_DEPTH) begin
        pend_dir[tail] = it.dir;
        tail = (tail == CMDQ_DEPTH - 1) ? 0 : tail + 1;
        backlog++;
      end else begin
        r.cmd_dropped = 1'b1;  // ring full
      end
    end else begin
      // idle controller picks up the next command on a tick
      if (!busy && backlog != 0) begin
        heading = pend_dir[head];
        head = (head == CMDQ_DEPTH - 1) ? 0 : head + 1;
        backlog--;
        goal = (heading == DIR_CW) ? it.count + rev_counts : it.count - rev_counts;
        busy = 1'b1;
      end
      if (busy) begin
        // plain difference, no wrap handling
        span = (goal >= it.count) ? goal - it.count : it.count - goal;
        if (span == '0) begin
          busy = 1'b0;
        end else begin
          span32 = span;
          top32 = top_duty;
          rev32 = rev_counts;
          scaled = (rev32 == 0) ? top32 : (span32 * top32) / rev32;
          if (scaled > top32) scaled = top32;
          if (scaled < floor_duty) scaled = floor_duty;  // min applied last
          r.duty = scaled[DUTY_W-1:0];
        end
      end
    end
    r.drive_dir = heading;
    r.moving = busy;
    r.queue_level = backlog[LEVEL_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t row(input logic req, input logic dir,
                                    input logic [COUNT_W-1:0] cnt, input bit typed,
                                    input logic [DUTY_W-1:0] d, input logic dd,
                                    input logic mv, input logic dr,
                                    input logic [LEVEL_W-1:0] lv);
    stim_row_t s;
    s.req = req;
    s.dir = dir;
    s.cnt = cnt;
    s.typed = typed;
    s.want.duty = d;
    s.want.drive_dir = dd;
    s.want.moving = mv;
    s.want.cmd_dropped = dr;
    s.want.queue_level = lv;
    return s;
  endfunction

  // Random item, mostly well-formed: enqueue when nothing is queued, then
  // ticks walking the count toward the target and landing on it
  function automatic item_t pick_item(input int unsigned cmd_pct);
    item_t it;
    logic [COUNT_W-1:0] span, stride;
    int unsigned sel, pct;
    it.dir = 1'($urandom_range(0, 1));
    it.count = 16'($urandom);
    pct = (!busy && backlog == 0) ? 70 : cmd_pct;
    it.is_tick = ($urandom_range(0, 99) < pct) ? REQ_CMD : REQ_TICK;
    if (it.is_tick == REQ_TICK) begin
      sel = $urandom_range(0, 99);
      if (busy) begin
        span = (goal >= walk) ? goal - walk : walk - goal;
        if (sel < 30 || span == '0) begin
          it.count = goal;
        end else if (sel < 80) begin
          stride = 16'($urandom_range(1, span));
          it.count = (goal >= walk) ? walk + stride : walk - stride;
        end else if (sel < 88) begin
          it.count = goal ^ 16'h0001;
        end
      end else if (sel < 10) begin
        it.count = sel[0] ? 16'hFFFF : 16'h0000;
      end
      walk = it.count;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input and register drivers; called at a falling edge, return at one
  // ---------------------------------------------------------------------------
  task automatic offer_item(input item_t it, input bit typed, input res_t want);
    res_t predicted;
    in_valid <= 1'b1;
    req_type <= it.is_tick;
    cmd_dir <= it.dir;
    position <= it.count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = motor_response(it);
    pending_drive.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // random sender gap; within a run valid only drops here, so never low and high in one step
  task automatic maybe_pause();
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_reg(idx, data);
    @(negedge clk);
  endtask

  // One phase: drain, reprogram while idle, then a run of random items
  task automatic run_phase(input logic [COUNT_W-1:0] cpr, input logic [DUTY_W-1:0] dmax,
                           input logic [DUTY_W-1:0] dmin, input int unsigned n,
                           input int unsigned cmd_pct, input int unsigned gap_pct,
                           input int unsigned stall_pct, input bit squeeze);
    item_t it;
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    // upper byte of the duty writes is junk the block must drop
    write_reg(CFG_COUNTS_PER_REV, cpr);
    write_reg(CFG_DUTY_MAX, {8'($urandom), dmax});
    write_reg(CFG_DUTY_MIN, {8'($urandom), dmin});
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    tx_gap_pct = gap_pct;
    rx_stall_pct = stall_pct;
    if (squeeze) hold_req = 1'b1;
    for (int unsigned k = 0; k < n; k++) begin
      it = pick_item(cmd_pct);
      offer_item(it, 1'b0, '0);
      maybe_pause();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_stall_pct != 0 &&
                   $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Each taken result against the oldest owed one, field by field
  always @(posedge clk) begin : drive_check
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_drive.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("mismatch: result with none owed, duty=%0d dir=%0d mov=%0d drop=%0d lvl=%0d",
                   duty, drive_dir, moving, cmd_dropped, queue_level);
      end else begin
        want = pending_drive.pop_front();
        if (duty !== want.duty || drive_dir !== want.drive_dir ||
            moving !== want.moving || cmd_dropped !== want.cmd_dropped ||
            queue_level !== want.queue_level) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("mismatch at %0t: duty %0d/%0d dir %0d/%0d mov %0d/%0d drop %0d/%0d lvl %0d/%0d (exp/got)",
                     $realtime, want.duty, duty, want.drive_dir, drive_dir,
                     want.moving, moving, want.cmd_dropped, cmd_dropped,
                     want.queue_level, queue_level);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t script[$];
    item_t it;
    // Directed part at reset settings (4480 counts, duty 100, min 0).
    // Results typed in where obvious; the rest go through the shadow.
    script = '{
      // ticks with nothing queued, count extremes
      row(REQ_TICK, DIR_CW,  16'h0000, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd0),
      row(REQ_TICK, DIR_CCW, 16'hFFFF, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd0),
      // fill the ring, alternating directions
      row(REQ_CMD, DIR_CW,  16'hFFFF, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd1),
      row(REQ_CMD, DIR_CCW, 16'h0000, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd2),
      row(REQ_CMD, DIR_CW,  16'hFFFF, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd3),
      row(REQ_CMD, DIR_CCW, 16'h0000, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd4),
      row(REQ_CMD, DIR_CW,  16'hFFFF, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd5),
      row(REQ_CMD, DIR_CCW, 16'h0000, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd6),
      row(REQ_CMD, DIR_CW,  16'hFFFF, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd7),
      row(REQ_CMD, DIR_CCW, 16'h0000, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd8),
      row(REQ_CMD, DIR_CW,  16'hFFFF, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd9),
      row(REQ_CMD, DIR_CCW, 16'h0000, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd10),
      row(REQ_CMD, DIR_CW,  16'hFFFF, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd11),
      row(REQ_CMD, DIR_CCW, 16'h0000, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd12),
      row(REQ_CMD, DIR_CW,  16'hFFFF, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd13),
      row(REQ_CMD, DIR_CCW, 16'h0000, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd14),
      row(REQ_CMD, DIR_CW,  16'hFFFF, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd15),
      row(REQ_CMD, DIR_CCW, 16'h0000, 1, 0, DIR_CW, 1'b0, 1'b0, 5'd16),
      // ring full: dropped
      row(REQ_CMD, DIR_CCW, 16'hFFFF, 1, 0, DIR_CW, 1'b0, 1'b1, 5'd16),
      // cw move from 0: full revolution away, top duty; then land on target
      row(REQ_TICK, DIR_CW,  16'h0000, 1, 100, DIR_CW, 1'b1, 1'b0, 5'd15),
      row(REQ_TICK, DIR_CCW, 16'd4480, 1, 0,   DIR_CW, 1'b0, 1'b0, 5'd15),
      // ccw move from 0 wraps the target; no wrap in the distance
      row(REQ_TICK, DIR_CW,  16'h0000, 0, 0, DIR_CW, 1'b0, 1'b0, 5'd0),
      row(REQ_TICK, DIR_CW,  16'hFFFF, 0, 0, DIR_CW, 1'b0, 1'b0, 5'd0),
      row(REQ_TICK, DIR_CCW, 16'd61056, 0, 0, DIR_CW, 1'b0, 1'b0, 5'd0),
      row(REQ_CMD,  DIR_CCW, 16'h5A5A, 0, 0, DIR_CW, 1'b0, 1'b0, 5'd0)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_gap_pct = 20;
    rx_stall_pct = 10;

    foreach (script[i]) begin
      it.is_tick = script[i].req;
      it.dir = script[i].dir;
      it.count = script[i].cnt;
      offer_item(it, script[i].typed, script[i].want);
      maybe_pause();
    end

    // Random phases: extremes of every register, zero revolution,
    // min above max, zero top duty, and one long receiver hold-off
    run_phase(16'd1,     8'd255, 8'd0,   160, 25, 15, 10, 1'b0);
    run_phase(16'd65535, 8'd255, 8'd255, 160, 30, 0,  0,  1'b0);
    run_phase(16'd0,     8'd255, 8'd0,   160, 30, 20, 15, 1'b0);
    run_phase(16'd100,   8'd50,  8'd200, 160, 20, 10, 10, 1'b0);
    run_phase(16'd16,    8'd0,   8'd0,   160, 25, 10, 10, 1'b0);
    run_phase(16'($urandom_range(1, 65535)), 8'($urandom), 8'($urandom),
              160, 40, 0, 10, 1'b1);
    run_phase(16'd7,     8'd1,   8'd1,   160, 60, 10, 10, 1'b0);
    run_phase(16'($urandom_range(1, 2000)), 8'($urandom), 8'($urandom),
              160, 25, 15, 15, 1'b0);
    // closing stretch, back at reset values, no idling on either side
    run_phase(CPR_RST, DUTY_MAX_RST, DUTY_MIN_RST, 160, 25, 0, 0, 1'b0);

    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/emc_pkg.sv
rtl/emc_ram.sv
rtl/emc_front.sv
rtl/emc_back.sv
rtl/encoder_move_controller.sv
bench/tb_encoder_move_controller.sv
